[rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg
// shared widths, fixed-point formats, stage records and shade coding for the
// mandelbrot escape-time pipeline
// ----------------------------------------------------------------------------
package mbe_pkg;

  // fixed-point formats: c is q2.13, z is q4.Z_FRAC_BITS
  localparam int Z_FRAC_BITS = 27;
  localparam int Z_INT_BITS  = 4;
  localparam int Z_W         = Z_FRAC_BITS + Z_INT_BITS + 1;
  localparam int P_W         = 2 * Z_W;
  localparam int C_FRAC_BITS = 13;
  localparam int C_W         = 16;
  localparam int C_SHIFT     = Z_FRAC_BITS - C_FRAC_BITS;

  localparam int CNT_W       = 6;
  localparam int SHADE_W     = 3;
  localparam int NUM_ITER    = 1 << CNT_W;

  typedef logic signed [Z_W-1:0] zval_t;
  typedef logic signed [C_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [SHADE_W-1:0]    shade_t;

  localparam int    ESCAPE_BOUND   = 2;
  localparam zval_t Z_BOUND        = zval_t'(longint'(ESCAPE_BOUND) << Z_FRAC_BITS);
  localparam zval_t Z_BOUND_NEG    = -Z_BOUND;
  localparam count_t MAX_ITER_RESET = count_t'(25);

  // shade thresholds on the count
  localparam count_t CLASS_EDGE_A = count_t'(3);
  localparam count_t CLASS_EDGE_B = count_t'(5);
  localparam count_t CLASS_EDGE_C = count_t'(10);

  // shade codes
  localparam shade_t SHADE_BELOW_A = shade_t'(0);
  localparam shade_t SHADE_BELOW_B = shade_t'(1);
  localparam shade_t SHADE_BELOW_C = shade_t'(2);
  localparam shade_t SHADE_OUTSIDE = shade_t'(3);
  localparam shade_t SHADE_IN_SET  = shade_t'(4);

  // one item between iterations
  typedef struct packed {
    logic   valid;
    logic   done;
    count_t count;
    zval_t  zr;
    zval_t  zi;
    coord_t cr;
    coord_t ci;
  } mbe_stage_t;

  // one item between the multiply and the update half of an iteration
  typedef struct packed {
    logic   valid;
    logic   done;
    count_t count;
    zval_t  zrs;
    zval_t  zis;
    zval_t  zri2;
    coord_t cr;
    coord_t ci;
  } mbe_prod_t;

  // q2.13 to q4.Z_FRAC_BITS, exact
  function automatic zval_t c_to_z(input coord_t c);
    zval_t ext;
    ext = zval_t'(c);
    return ext <<< C_SHIFT;
  endfunction

  function automatic shade_t shade_of(input count_t cnt, input count_t max_iter);
    shade_t s;
    if (cnt < CLASS_EDGE_A) begin
      s = SHADE_BELOW_A;
    end else if (cnt < CLASS_EDGE_B) begin
      s = SHADE_BELOW_B;
    end else if (cnt < CLASS_EDGE_C) begin
      s = SHADE_BELOW_C;
    end else if (cnt < max_iter) begin
      s = SHADE_OUTSIDE;
    end else begin
      s = SHADE_IN_SET;
    end
    return s;
  endfunction

endpackage

[rtl/mbe_if.sv]
// ----------------------------------------------------------------------------
// mbe channel interfaces
// valid/ready channels for pixel requests, results and the limit register
// ----------------------------------------------------------------------------
interface mbe_pixel_if import mbe_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t c_real;
  coord_t c_imag;

  modport source (output valid, c_real, c_imag, input ready);
  modport sink   (input valid, c_real, c_imag, output ready);
endinterface

interface mbe_result_if import mbe_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t escape_count;
  shade_t shade_class;

  modport source (output valid, escape_count, shade_class, input ready);
  modport sink   (input valid, escape_count, shade_class, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t max_iterations;

  modport source (output valid, max_iterations, input ready);
  modport sink   (input valid, max_iterations, output ready);
endinterface

[rtl/mandelbrot_escape_count.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// escape-time count and shade class for one point c per request
// ----------------------------------------------------------------------------
// pipeline of 64 iterations of two register stages each, then the result
//   register
// throughput: one request per cycle; the whole pipeline holds while a result
//   waits to be taken
// reset: clears all valid bits and sets max_iterations to 25
// ----------------------------------------------------------------------------
module mandelbrot_escape_count import mbe_pkg::*; (
  input logic          clk,
  input logic          rst,
  mbe_pixel_if.sink    pixel,
  mbe_cfg_if.sink      cfg,
  mbe_result_if.source result
);

  // iteration limit register; the user must write it only while the pipeline is empty, the block does not enforce this
  count_t max_iter;

  // stage records between iterations: stg[0] is the incoming request,
  // stg[k] is the item after update k-1
  mbe_stage_t stg [0:NUM_ITER];

  // one enable for every stage: advance whenever the result slot is free or
  // being drained this cycle, so nothing is lost or repeated on a stall
  logic en;

  logic   res_valid;
  count_t res_count;
  shade_t res_shade;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RESET;
    end else if (cfg.valid) begin
      max_iter <= cfg.max_iterations;
    end
  end

  assign en          = !res_valid || result.ready;
  assign pixel.ready = en;

  // z starts at zero, count at zero
  always_comb begin
    stg[0].valid = pixel.valid;
    stg[0].done  = 1'b0;
    stg[0].count = '0;
    stg[0].zr    = '0;
    stg[0].zi    = '0;
    stg[0].cr    = pixel.c_real;
    stg[0].ci    = pixel.c_imag;
  end

  // unrolled iterations; an item that has escaped or hit the limit rides
  // along with its count frozen
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
    mbe_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .iter_index(count_t'(i)),
      .max_iter  (max_iter),
      .stage_in  (stg[i]),
      .stage_out (stg[i+1])
    );
  end

  // result register with shade lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= stg[NUM_ITER].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_count <= stg[NUM_ITER].count;
      res_shade <= shade_of(stg[NUM_ITER].count, max_iter);
    end
  end

  assign result.valid        = res_valid;
  assign result.escape_count = res_count;
  assign result.shade_class  = res_shade;

  // only the five shade codes come out
  a_shade_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_shade <= SHADE_IN_SET)
    else $error("shade code out of range");

  // in-set class needs at least the top threshold
  a_in_set_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_shade == SHADE_IN_SET |-> res_count >= CLASS_EDGE_C)
    else $error("in-set shade with small count");

  // large counts land in one of the two top classes
  a_high_class: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_count >= CLASS_EDGE_C |->
      res_shade == SHADE_OUTSIDE || res_shade == SHADE_IN_SET)
    else $error("large count with low shade");

endmodule

[rtl/mbe_iter.sv]
// ----------------------------------------------------------------------------
// mbe_iter
// one z = z*z + c iteration in two register stages: products, then update
// and box test
// ----------------------------------------------------------------------------
module mbe_iter import mbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  count_t     iter_index,
  input  count_t     max_iter,
  input  mbe_stage_t stage_in,
  output mbe_stage_t stage_out
);

  zval_t            zr;
  zval_t            zi;
  logic signed [P_W-1:0] sq_r;
  logic signed [P_W-1:0] sq_i;
  logic signed [P_W-1:0] prod_x;
  mbe_prod_t        prod;
  mbe_prod_t        prod_next;

  zval_t            zr_new;
  zval_t            zi_new;
  logic             escape;
  logic             stop;
  mbe_stage_t       stage_next;

  // stage a: exact products, truncated toward minus infinity
  assign zr     = stage_in.zr;
  assign zi     = stage_in.zi;
  assign sq_r   = P_W'(zr) * P_W'(zr);
  assign sq_i   = P_W'(zi) * P_W'(zi);
  assign prod_x = P_W'(zi) * P_W'(zr);

  always_comb begin
    prod_next.valid = stage_in.valid;
    prod_next.done  = stage_in.done;
    prod_next.count = stage_in.count;
    prod_next.zrs   = sq_r[Z_FRAC_BITS +: Z_W];
    prod_next.zis   = sq_i[Z_FRAC_BITS +: Z_W];
    // doubling folded into the shift
    prod_next.zri2  = prod_x[Z_FRAC_BITS-1 +: Z_W];
    prod_next.cr    = stage_in.cr;
    prod_next.ci    = stage_in.ci;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod <= prod_next;
    end
  end

  // stage b: update, box test, count
  always_comb begin
    zr_new = prod.zrs - prod.zis + c_to_z(prod.cr);
    zi_new = prod.zri2 + c_to_z(prod.ci);
    escape = (zr_new > Z_BOUND) || (zi_new > Z_BOUND) ||
             (zr_new < Z_BOUND_NEG) || (zi_new < Z_BOUND_NEG);
    stop   = escape || (iter_index == max_iter);

    stage_next.valid = prod.valid;
    stage_next.done  = prod.done | stop;
    stage_next.count = (prod.done || stop) ? prod.count : count_t'(prod.count + 1'b1);
    stage_next.zr    = zr_new;
    stage_next.zi    = zi_new;
    stage_next.cr    = prod.cr;
    stage_next.ci    = prod.ci;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out <= stage_next;
    end
  end

  // a live item has counted exactly one step per iteration
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    stage_out.valid && !stage_out.done |-> stage_out.count == count_t'(iter_index + 1'b1))
    else $error("live item count out of step");

  // a finished item never counts past its iteration
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    stage_out.valid && stage_out.done |-> stage_out.count <= iter_index)
    else $error("finished item count too large");

  // a finished item passes through unchanged
  a_done_frozen: assert property (@(posedge clk) disable iff (rst)
    en && prod.valid && prod.done |=> stage_out.done && stage_out.count == $past(prod.count))
    else $error("finished item changed");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the mandelbrot escape-time pipeline. A table of directed points
// comes first, then random points under several iteration limits. Every
// result is compared with its typed-in value or a bit-exact fixed-point model
// of the iteration kept in this bench. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb import mbe_pkg::*; ();

  // pipeline depth from request to result
  localparam int LATENCY      = 129;
  localparam int HOLD_CYCLES  = 400;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int N_ROWS       = 25;
  localparam int MAX_REPORTS  = 10;
  localparam int TIMEOUT_NS   = 10_000_000;

  // +-2.0 in the z format; a part equal to the edge has not escaped
  localparam zval_t ESCAPE_EDGE = zval_t'(64'sd2 <<< Z_FRAC_BITS);

  // what one pixel request should produce
  typedef struct {
    coord_t cr;
    coord_t ci;
    count_t limit;
    count_t count;
    shade_t shade;
  } pixel_expect_t;

  // one directed request; known rows carry their result typed in
  typedef struct {
    count_t limit;
    coord_t cr;
    coord_t ci;
    bit     known;
    count_t count;
    shade_t shade;
  } pixel_row_t;

  logic clk;
  logic rst;

  mbe_pixel_if  pix_ch ();
  mbe_cfg_if    cfg_ch ();
  mbe_result_if res_ch ();

  mandelbrot_escape_count dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  // results still owed by the block, oldest first
  pixel_expect_t escape_due_q[$];

  count_t cur_limit = MAX_ITER_RESET;
  int     errors = 0;
  int     requests_sent = 0;
  int     limits_written = 0;
  int     input_stall_cycles = 0;
  int     shade_hits[5] = '{0, 0, 0, 0, 0};
  bit     hold_req = 1'b0;
  bit     sink_quiet = 1'b0;

  // directed points, grouped by the limit they run under
  pixel_row_t rows [N_ROWS] = '{
    // reset limit of 25
    '{25,      0,      0, 1'b1, 25, SHADE_IN_SET},   // origin stays put
    '{25, -32768,      0, 1'b1,  0, SHADE_BELOW_A},  // most negative real
    '{25,  32767,      0, 1'b1,  0, SHADE_BELOW_A},  // most positive real
    '{25,      0, -32768, 1'b1,  0, SHADE_BELOW_A},
    '{25,      0,  32767, 1'b1,  0, SHADE_BELOW_A},
    '{25, -32768, -32768, 1'b1,  0, SHADE_BELOW_A},
    '{25,  32767,  32767, 1'b1,  0, SHADE_BELOW_A},
    '{25, -16384,      0, 1'b1, 25, SHADE_IN_SET},   // sits on -2.0 then 2.0
    '{25,  16384,      0, 1'b1,  1, SHADE_BELOW_A},  // 2.0 holds, next is 6.0
    '{25,      0,  16384, 1'b1,  1, SHADE_BELOW_A},  // 2i then -4+2i
    '{25,      0, -16384, 1'b1,  1, SHADE_BELOW_A},
    '{25,  -8192,      0, 1'b1, 25, SHADE_IN_SET},   // -1 and 0 alternate
    '{25,  16385,      0, 1'b1,  0, SHADE_BELOW_A},  // one lsb past the edge
    '{25, -16385,      0, 1'b1,  0, SHADE_BELOW_A},
    '{25,   2048,      0, 1'b0, '0, '0},             // cusp, slow approach
    '{25,  -6144,    819, 1'b0, '0, '0},
    // top limit
    '{63,      0,      0, 1'b1, 63, SHADE_IN_SET},
    '{63, -16384,      0, 1'b1, 63, SHADE_IN_SET},
    '{63,  -6144,    819, 1'b0, '0, '0},
    '{63,   2458,   4096, 1'b0, '0, '0},
    // limit of one: count below the first edge wins over in-set
    '{ 1,      0,      0, 1'b1,  1, SHADE_BELOW_A},
    '{ 1,  16384,      0, 1'b1,  1, SHADE_BELOW_A},
    '{ 1,  32767,  32767, 1'b1,  0, SHADE_BELOW_A},
    // limit of zero: a single update, count 0
    '{ 0,      0,      0, 1'b1,  0, SHADE_BELOW_A},
    '{ 0, -32768,      0, 1'b1,  0, SHADE_BELOW_A}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // escape-time model: q2.13 c widened to the z format, exact 64-bit
  // products, low fraction bits dropped (floor), box test after each update
  // --------------------------------------------------------------------------
  function automatic pixel_expect_t escape_predict(input coord_t cr, input coord_t ci,
                                                   input count_t limit);
    zval_t                 cr_z, ci_z, zr, zi, next_r, next_i;
    logic signed [P_W-1:0] wr, wi, sq_r, sq_i, twice;
    count_t                n;
    bit                    running, escaped;
    pixel_expect_t         e;
    cr_z = {{(Z_W - C_W - C_SHIFT){cr[C_W-1]}}, cr, {C_SHIFT{1'b0}}};
    ci_z = {{(Z_W - C_W - C_SHIFT){ci[C_W-1]}}, ci, {C_SHIFT{1'b0}}};
    zr = '0;
    zi = '0;
    n = '0;
    running = 1'b1;
    while (running) begin
      wr = zr;
      wi = zi;
      sq_r  = (wr * wr) >>> Z_FRAC_BITS;
      sq_i  = (wi * wi) >>> Z_FRAC_BITS;
      // doubling folded into a shift one short
      twice = (wr * wi) >>> (Z_FRAC_BITS - 1);
      next_r = zval_t'(sq_r - sq_i + cr_z);
      next_i = zval_t'(twice + ci_z);
      escaped = (next_r > ESCAPE_EDGE) || (next_r < -ESCAPE_EDGE) ||
                (next_i > ESCAPE_EDGE) || (next_i < -ESCAPE_EDGE);
      zr = next_r;
      zi = next_i;
      if (escaped) begin
        running = 1'b0;
      end else if (n < limit) begin
        n = n + 1'b1;
      end else begin
        running = 1'b0;
      end
    end
    e.cr = cr;
    e.ci = ci;
    e.limit = limit;
    e.count = n;
    // edges tested in order, so a small limit can beat the in-set class
    if (n < CLASS_EDGE_A) begin
      e.shade = SHADE_BELOW_A;
    end else if (n < CLASS_EDGE_B) begin
      e.shade = SHADE_BELOW_B;
    end else if (n < CLASS_EDGE_C) begin
      e.shade = SHADE_BELOW_C;
    end else if (n < limit) begin
      e.shade = SHADE_OUTSIDE;
    end else begin
      e.shade = SHADE_IN_SET;
    end
    return e;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic coord_t pick_coord(input bit imag_part);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      // around the set: real -2.0..0.5, imaginary -1.2..1.2
      if (imag_part) return coord_t'(int'($urandom_range(0, 19660)) - 9830);
      return coord_t'(int'($urandom_range(0, 20480)) - 16384);
    end
    if (r < 75) begin
      // a few lsbs either side of +-2.0
      return coord_t'(($urandom_range(0, 1) ? 16384 : -16384) +
                      int'($urandom_range(0, 4)) - 2);
    end
    return coord_t'($urandom);
  endfunction

  // present one pixel request after a gap, return at the accepting edge
  task automatic offer_pixel(input coord_t cr, input coord_t ci, input int unsigned gap);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid  <= 1'b1;
    pix_ch.c_real <= cr;
    pix_ch.c_imag <= ci;
    do @(posedge clk); while (!pix_ch.ready);
    requests_sent++;
  endtask

  // stop requesting and wait until every owed result is back
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (escape_due_q.size() != 0);
  endtask

  task automatic write_limit(input count_t v);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.max_iterations <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_limit = v;
    limits_written++;
  endtask

  // --------------------------------------------------------------------------
  // result side: check every accepted result, then pick the next ready.
  // a hold request parks ready low for a long counted stretch
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned   stall_left;
    pixel_expect_t want;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        if (escape_due_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("  %0t: result count %0d shade %0d with no request pending",
                     $time, res_ch.escape_count, res_ch.shade_class);
        end else begin
          want = escape_due_q.pop_front();
          shade_hits[want.shade]++;
          if (res_ch.escape_count !== want.count || res_ch.shade_class !== want.shade) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("  %0t: c=(%0d,%0d) limit %0d: got count %0d shade %0d, exp %0d %0d",
                       $time, want.cr, want.ci, want.limit, res_ch.escape_count,
                       res_ch.shade_class, want.count, want.shade);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (!sink_quiet) begin
        stall_left = pick_gap();
      end
      res_ch.ready <= (stall_left == 0);
    end
  end

  // input back-pressure seen while requests are offered
  always @(posedge clk) begin
    if (pix_ch.valid && !pix_ch.ready)
      input_stall_cycles++;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    count_t lim;
    coord_t cr, ci;
    bit     src_quiet;
    rst                   <= 1'b1;
    pix_ch.valid          <= 1'b0;
    pix_ch.c_real         <= '0;
    pix_ch.c_imag         <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.max_iterations <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table; limit changes only once the pipeline is empty
    for (int k = 0; k < N_ROWS; k++) begin
      if (rows[k].limit != cur_limit) begin
        drain_results();
        write_limit(rows[k].limit);
      end
      offer_pixel(rows[k].cr, rows[k].ci, pick_gap());
      if (rows[k].known)
        escape_due_q.push_back('{rows[k].cr, rows[k].ci, cur_limit,
                                 rows[k].count, rows[k].shade});
      else
        escape_due_q.push_back(escape_predict(rows[k].cr, rows[k].ci, cur_limit));
    end

    // random phases, each under its own limit
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       lim = 6'd63;
        1:       lim = 6'd10;
        2:       lim = 6'd1;
        3:       lim = 6'd5;
        5:       lim = 6'd63;
        7:       lim = 6'd9;
        default: lim = count_t'($urandom_range(1, 63));
      endcase
      drain_results();
      write_limit(lim);
      src_quiet  = (p % 3 == 2) || (p == 5);
      sink_quiet = (p % 4 == 1);
      // long receiver hold while requests keep coming back to back
      if (p == 5)
        hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender pauses midway until every result is back
        if (p == 3 && k == PHASE_ITEMS / 2)
          drain_results();
        cr = pick_coord(1'b0);
        ci = pick_coord(1'b1);
        offer_pixel(cr, ci, src_quiet ? 0 : pick_gap());
        escape_due_q.push_back(escape_predict(cr, ci, cur_limit));
      end
    end

    drain_results();
    // catch any stray result after the last one
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d pixel requests under %0d limit writes, %0d stalled input cycles",
             requests_sent, limits_written, input_stall_cycles);
    $display("shade classes seen (0..4): %0d %0d %0d %0d %0d, %0d failures",
             shade_hits[0], shade_hits[1], shade_hits[2], shade_hits[3], shade_hits[4],
             errors);
    if (errors == 0) begin
      $display("** mandelbrot_escape_count: PASSED **");
    end else begin
      $display("** mandelbrot_escape_count: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** mandelbrot_escape_count: FAILED **");
    $finish;
  end

endmodule
